// ===== hw/rtl/cal_pkg.sv =====
// Shared command, status and cell control types for the cursor array list.
package cal_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [3:0] {
		CMD_CLEAR  = 4'd0,
		CMD_INSERT = 4'd1,
		CMD_APPEND = 4'd2,
		CMD_REMOVE = 4'd3,
		CMD_START  = 4'd4,
		CMD_END    = 4'd5,
		CMD_PREV   = 4'd6,
		CMD_NEXT   = 4'd7,
		CMD_MOVE   = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_CUR   = 2'd2,
		ST_BAD_POS  = 2'd3
	} status_t;

	// Broadcast to every cell; at most one bit is set, and only when the command succeeds.
	typedef struct packed {
		logic ins;
		logic app;
		logic rem;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/cal_cell.sv =====
// One list slot: holds an entry and takes a new value or a neighbor's entry.
module cal_cell #(
	parameter int unsigned CAPACITY   = cal_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = cal_pkg::DATA_WIDTH_DEF,
	parameter int unsigned IDX        = 0,
	localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  en,
	input  cal_pkg::cell_cmd_t    cell_cmd,
	input  logic [CW-1:0]         cursor,
	input  logic [CW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] entry
);

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX_N  = CW'(IDX + 1);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  load_value;
	logic                  load_left;
	logic                  load_right;

	// Insert opens a gap at the cursor by moving every entry from there up by one.
	assign load_value = (cell_cmd.ins && IDX_C == cursor) || (cell_cmd.app && IDX_C == count);
	assign load_left  = cell_cmd.ins && IDX_C > cursor && IDX_C <= count;
	assign load_right = cell_cmd.rem && IDX_C >= cursor && IDX_N < count;

	always_ff @(posedge clk) begin
		if (en) begin
			if (load_value) begin
				entry_q <= value;
			end else if (load_left) begin
				entry_q <= left;
			end else if (load_right) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;

endmodule

// ===== hw/rtl/cal_ctrl.sv =====
// Command decoder holding the entry count and cursor.
module cal_ctrl #(
	parameter int unsigned CAPACITY = cal_pkg::CAPACITY_DEF,
	localparam int unsigned CW      = $clog2(CAPACITY + 1),
	localparam int unsigned PW      = (CW > 5) ? CW : 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [3:0]         cmd,
	input  logic [4:0]         position,
	output logic [CW-1:0]      count,
	output logic [CW-1:0]      cursor,
	output cal_pkg::cell_cmd_t cell_cmd,
	output cal_pkg::status_t   status
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      count_d;
	logic [CW-1:0]      cursor_d;
	logic               full;
	logic               at_end;
	logic               pos_bad;

	assign full    = count_q >= CAP_C;
	assign at_end  = cursor_q >= count_q;
	assign pos_bad = PW'(position) > PW'(count_q);

	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		status   = cal_pkg::ST_OK;
		cell_cmd = '0;
		unique case (cal_pkg::cmd_t'(cmd))
			cal_pkg::CMD_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
			end
			cal_pkg::CMD_INSERT, cal_pkg::CMD_APPEND: begin
				if (full) begin
					status = cal_pkg::ST_FULL;
				end else begin
					count_d      = count_q + 1'b1;
					cell_cmd.ins = (cal_pkg::cmd_t'(cmd) == cal_pkg::CMD_INSERT);
					cell_cmd.app = (cal_pkg::cmd_t'(cmd) == cal_pkg::CMD_APPEND);
				end
			end
			cal_pkg::CMD_REMOVE: begin
				if (at_end) begin
					status = cal_pkg::ST_NO_CUR;
				end else begin
					count_d      = count_q - 1'b1;
					cell_cmd.rem = 1'b1;
				end
			end
			cal_pkg::CMD_START: cursor_d = '0;
			cal_pkg::CMD_END:   cursor_d = count_q;
			cal_pkg::CMD_PREV: begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - 1'b1;
				end
			end
			cal_pkg::CMD_NEXT: begin
				if (!at_end) begin
					cursor_d = cursor_q + 1'b1;
				end
			end
			cal_pkg::CMD_MOVE: begin
				if (pos_bad) begin
					status = cal_pkg::ST_BAD_POS;
				end else begin
					cursor_d = CW'(PW'(position));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (en) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	assign count  = count_q;
	assign cursor = cursor_q;

endmodule

// ===== hw/rtl/cursor_array_list.sv =====
// Top level of the cursor array list: stream ports, cell chain and result register.
//
//  channel   dir  fields (tdata, lowest bit first)
//  s_axis    in   cmd[3:0] element_value[35:4] position[40:36], zero to 48 bits
//  m_axis    out  status[1:0] removed_value[33:2] list_length[38:34]
//                 cursor_pos[43:39] current_value[75:44] current_valid[76], zero to 80
//
// Each request updates the cell chain at the accepting edge and its result is loaded
// in the following cycle; no new request is taken while that result waits to be loaded.
// Accept and load both read the cursor slot via one selection tree over the cells.
// Reset clears the count, the cursor and all handshake state; entries are not cleared.
// A stalled result holds the next request off until the output register has room.
module cursor_array_list #(
	parameter int unsigned CAPACITY   = cal_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = cal_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cmd, element_value, position
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // status, removed_value, list_length, cursor_pos,
	                               // current_value, current_valid
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic                  accept;
	logic [3:0]            cmd;
	logic [31:0]           element_value;
	logic [4:0]            position;
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] value;

	logic [CW-1:0]         count;
	logic [CW-1:0]         cursor;
	cal_pkg::cell_cmd_t    cell_cmd;
	cal_pkg::status_t      status;

	logic [DATA_WIDTH-1:0] entry [CAPACITY];
	logic [DATA_WIDTH-1:0] cur_read;

	logic                  work_s1;
	cal_pkg::status_t      status_s1;
	logic [DATA_WIDTH-1:0] removed_s1;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [31:0]           removed_q;
	logic [4:0]            length_q;
	logic [4:0]            cursor_q;
	logic [31:0]           current_q;
	logic                  cur_valid_q;
	logic                  cur_valid;
	logic [63:0]           removed_ext;
	logic [63:0]           cur_ext;

	assign cmd           = s_tdata[3:0];
	assign element_value = s_tdata[35:4];
	assign position      = s_tdata[40:36];
	assign value_ext     = 64'(element_value);
	assign value         = value_ext[DATA_WIDTH-1:0];

	assign s_tready = !work_s1 && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	cal_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept),
		.cmd      (cmd),
		.position (position),
		.count    (count),
		.cursor   (cursor),
		.cell_cmd (cell_cmd),
		.status   (status)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;

		if (i == 0) begin : g_first
			assign left = value;
		end else begin : g_left
			assign left = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = entry[i+1];
		end

		cal_cell #(
			.CAPACITY   (CAPACITY),
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk      (clk),
			.en       (accept),
			.cell_cmd (cell_cmd),
			.cursor   (cursor),
			.count    (count),
			.value    (value),
			.left     (left),
			.right    (right),
			.entry    (entry[i])
		);
	end

	// Before the update this is the entry a remove takes out; after it, the current entry.
	always_comb begin
		cur_read = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cursor == CW'(i)) begin
				cur_read = cur_read | entry[i];
			end
		end
	end

	assign cur_valid = cursor < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_s1 <= 1'b0;
		end else begin
			work_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status;
			removed_s1 <= cell_cmd.rem ? cur_read : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign removed_ext = 64'(removed_s1);
	assign cur_ext     = cur_valid ? 64'(cur_read) : 64'd0;

	always_ff @(posedge clk) begin
		if (work_s1) begin
			status_q    <= status_s1;
			removed_q   <= removed_ext[31:0];
			length_q    <= 5'(count);
			cursor_q    <= 5'(cursor);
			current_q   <= cur_ext[31:0];
			cur_valid_q <= cur_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, cur_valid_q, current_q, cursor_q, length_q, removed_q, status_q};

`ifndef SYNTHESIS
	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cursor <= count)
		else $error("cursor beyond entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 m_tvalid)
		else $error("accepted request produced no result");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		work_s1 && status_s1 != cal_pkg::ST_OK |-> count == $past(count) && cursor == $past(cursor))
		else $error("state changed on a flagged error");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		work_s1 |-> !out_valid_q || $past(m_tready))
		else $error("result register overwritten while full");
`endif

endmodule
